>>> rtl/core/stt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kind codes and the keyword table of the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Width of the read position; offsets wrap modulo 2**OFFSET_BITS.
	localparam int OFFSET_BITS = 16;
	// Run length register width; saturates at min(2**OFFSET_BITS-1, 65535).
	localparam int LEN_BITS    = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;

	localparam int KIND_BITS = 6;
	localparam int FIELD_BITS = 16;
	localparam int KW_COUNT  = 15;

	typedef logic [KIND_BITS-1:0]   kind_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [LEN_BITS-1:0]    len_t;
	typedef logic [KW_COUNT-1:0]    kw_hits_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] length;
		logic                  last;
	} result_t;

	// Token kinds
	localparam kind_t K_EOF       = 6'd0;
	localparam kind_t K_NUMBER    = 6'd1;
	localparam kind_t K_IDENT     = 6'd2;
	localparam kind_t K_STRING    = 6'd3;
	localparam kind_t K_KW0       = 6'd4;
	localparam kind_t K_PLUS_GT   = 6'd19;
	localparam kind_t K_MINUS_LT  = 6'd20;
	localparam kind_t K_AND_AND   = 6'd21;
	localparam kind_t K_OR_OR     = 6'd22;
	localparam kind_t K_BANG      = 6'd23;
	localparam kind_t K_EQ_EQ     = 6'd24;
	localparam kind_t K_EQ        = 6'd25;
	localparam kind_t K_PLUS      = 6'd26;
	localparam kind_t K_MINUS     = 6'd27;
	localparam kind_t K_LT        = 6'd28;
	localparam kind_t K_GT        = 6'd29;
	localparam kind_t K_LBRACE    = 6'd30;
	localparam kind_t K_RBRACE    = 6'd31;
	localparam kind_t K_LPAREN    = 6'd32;
	localparam kind_t K_RPAREN    = 6'd33;
	localparam kind_t K_LBRACK    = 6'd34;
	localparam kind_t K_RBRACK    = 6'd35;

	// Keyword text, right-justified, first character in the highest used byte.
	function automatic logic [71:0] kw_word(input logic [3:0] k);
		logic [71:0] w;
		case (k)
			4'd0:    w = 72'h72_69_76_65_6e;
			4'd1:    w = "core";
			4'd2:    w = "stamp";
			4'd3:    w = "grab";
			4'd4:    w = "consistof";
			4'd5:    w = "if";
			4'd6:    w = "altif";
			4'd7:    w = "else";
			4'd8:    w = "flow";
			4'd9:    w = "during";
			4'd10:   w = "craft";
			4'd11:   w = "returns";
			4'd12:   w = "and";
			4'd13:   w = "or";
			4'd14:   w = "not";
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] k);
		logic [3:0] n;
		case (k)
			4'd0:    n = 4'd5;
			4'd1:    n = 4'd4;
			4'd2:    n = 4'd5;
			4'd3:    n = 4'd4;
			4'd4:    n = 4'd9;
			4'd5:    n = 4'd2;
			4'd6:    n = 4'd5;
			4'd7:    n = 4'd4;
			4'd8:    n = 4'd4;
			4'd9:    n = 4'd6;
			4'd10:   n = 4'd5;
			4'd11:   n = 4'd7;
			4'd12:   n = 4'd3;
			4'd13:   n = 4'd2;
			4'd14:   n = 4'd3;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Character idx (from the left) of keyword k; meaningless when idx >= length.
	function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] idx);
		logic [3:0]  sh;
		logic [71:0] w;
		sh = kw_len(k) - 4'd1 - idx;
		w  = kw_word(k) >> {sh, 3'b000};
		return w[7:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] off_field(input offset_t v);
		logic [OFFSET_BITS+FIELD_BITS-1:0] t;
		t = {{FIELD_BITS{1'b0}}, v};
		return t[FIELD_BITS-1:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] len_field(input len_t v);
		logic [LEN_BITS+FIELD_BITS-1:0] t;
		t = {{FIELD_BITS{1'b0}}, v};
		return t[FIELD_BITS-1:0];
	endfunction

	function automatic result_t mk_result(input kind_t kind,
	                                      input logic [FIELD_BITS-1:0] start,
	                                      input logic [FIELD_BITS-1:0] length);
		result_t r;
		r.kind   = kind;
		r.start  = start;
		r.length = length;
		r.last   = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/source_text_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte per item in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  text     | text_valid, text_ready, text_byte         | in
//  token    | token_valid, token_ready, token_kind,     | out
//           | token_start, token_length, last_of_run    |
//
// A byte is held in the input register, where the scanner turns it into zero
// to two tokens for a two-entry output queue: one byte per cycle while each
// byte yields at most one token and the token side keeps up. A two-token byte
// waits for an empty queue and the byte after it waits for a free slot.
// Reset or a zero byte brings position and scanner state back to their start.
// A stalled token side fills the queue and then stops the byte side.
module source_text_tokenizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_ready,
	input  wire logic [7:0]  text_byte,
	output logic             token_valid,
	input  wire logic        token_ready,
	output logic [5:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic             last_of_run
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             fire;
	logic [1:0]       res_cnt;
	stt_pkg::result_t res [2];
	logic [1:0]       q_count;
	stt_pkg::result_t head;
	logic [1:0]       push_cnt;
	logic [2:0]       need;

	stt_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_s1),
		.go      (fire),
		.res_cnt (res_cnt),
		.res     (res)
	);

	// room is judged on the registered count only, keeping token_ready off this path
	assign need       = {1'b0, q_count} + {1'b0, res_cnt};
	assign fire       = valid_s1 && (need <= 3'd2);
	assign text_ready = !valid_s1 || fire;
	assign push_cnt   = fire ? res_cnt : 2'd0;

	stt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (res),
		.pop       (token_valid && token_ready),
		.count     (q_count),
		.head      (head)
	);

	assign token_valid  = q_count != 2'd0;
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

	always_ff @(posedge clk) begin
		if (text_valid && text_ready)
			byte_s1 <= text_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && text_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/stt_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and per-byte next-state logic; yields up to two tokens per byte.
// ----------------------------------------------------------------------------
module stt_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        byte_in,
	input  wire logic              go,
	output logic [1:0]             res_cnt,
	output stt_pkg::result_t       res [2]
);

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_NUM   = 3'd1;
	localparam logic [2:0] M_IDENT = 3'd2;
	localparam logic [2:0] M_STR   = 3'd3;
	localparam logic [2:0] M_LINE  = 3'd4;
	localparam logic [2:0] M_BLOCK = 3'd5;

	localparam logic [2:0] P_NONE  = 3'd0;
	localparam logic [2:0] P_PLUS  = 3'd1;
	localparam logic [2:0] P_MINUS = 3'd2;
	localparam logic [2:0] P_AMP   = 3'd3;
	localparam logic [2:0] P_BAR   = 3'd4;
	localparam logic [2:0] P_EQ    = 3'd5;
	localparam logic [2:0] P_LESS  = 3'd6;
	localparam logic [2:0] P_TILDE = 3'd7;

	localparam stt_pkg::len_t LEN_MAX = '1;

	logic [2:0]        mode_q, mode_d;
	logic [2:0]        pend_q, pend_d;
	logic              saw_q, saw_d;
	stt_pkg::offset_t  rpos_q, rpos_d;
	stt_pkg::offset_t  start_q, start_d;
	stt_pkg::len_t     run_q, run_d;
	stt_pkg::kw_hits_t hits_q, hits_d;

	stt_pkg::kw_hits_t keep, first_hit;
	stt_pkg::kind_t    ident_kind;
	stt_pkg::len_t     run_bump;
	logic              is_dig, is_alp, is_idc;

	function automatic stt_pkg::len_t LEN_BITS_LEN(input logic [3:0] n);
		logic [stt_pkg::LEN_BITS+3:0] t;
		t = {{stt_pkg::LEN_BITS{1'b0}}, n};
		return t[stt_pkg::LEN_BITS-1:0];
	endfunction

	// Keyword match vectors and kind of the identifier held so far
	always_comb begin
		ident_kind = stt_pkg::K_IDENT;
		for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
			keep[k] = (run_q < LEN_BITS_LEN(stt_pkg::kw_len(4'(k))))
			          && (stt_pkg::kw_char(4'(k), run_q[3:0]) == byte_in);
			first_hit[k] = stt_pkg::kw_char(4'(k), 4'd0) == byte_in;
		end
		for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (hits_q[k] && run_q == LEN_BITS_LEN(stt_pkg::kw_len(4'(k))))
				ident_kind = stt_pkg::K_KW0 + stt_pkg::kind_t'(k);
		end
	end

	assign is_dig   = byte_in inside {[8'h30:8'h39]};
	assign is_alp   = byte_in inside {[8'h41:8'h5a], [8'h61:8'h7a]};
	assign is_idc   = is_dig || is_alp || byte_in == 8'h5f;
	assign run_bump = (run_q < LEN_MAX) ? run_q + 1'b1 : run_q;

	always_comb begin
		logic   fresh;
		stt_pkg::result_t r [2];
		logic [1:0] n;

		mode_d  = mode_q;
		pend_d  = pend_q;
		saw_d   = saw_q;
		rpos_d  = rpos_q;
		start_d = start_q;
		run_d   = run_q;
		hits_d  = hits_q;
		fresh   = 1'b1;
		n       = 2'd0;
		r[0]    = '0;
		r[1]    = '0;

		if (byte_in == 8'h00) begin
			case (mode_q)
				M_NUM: begin
					r[n[0]] = stt_pkg::mk_result(stt_pkg::K_NUMBER,
						stt_pkg::off_field(start_q), stt_pkg::len_field(run_q));
					n = n + 2'd1;
				end
				M_IDENT: begin
					r[n[0]] = stt_pkg::mk_result(ident_kind,
						stt_pkg::off_field(start_q), stt_pkg::len_field(run_q));
					n = n + 2'd1;
				end
				M_STR: begin
					r[n[0]] = stt_pkg::mk_result(stt_pkg::K_STRING,
						stt_pkg::off_field(start_q), stt_pkg::len_field(run_q));
					n = n + 2'd1;
				end
				default: ;
			endcase
			case (pend_q)
				P_PLUS: begin
					r[n[0]] = stt_pkg::mk_result(stt_pkg::K_PLUS,
						stt_pkg::off_field(start_q), 16'd1);
					n = n + 2'd1;
				end
				P_MINUS: begin
					r[n[0]] = stt_pkg::mk_result(stt_pkg::K_MINUS,
						stt_pkg::off_field(start_q), 16'd1);
					n = n + 2'd1;
				end
				P_EQ: begin
					r[n[0]] = stt_pkg::mk_result(stt_pkg::K_EQ,
						stt_pkg::off_field(start_q), 16'd1);
					n = n + 2'd1;
				end
				P_LESS: begin
					r[n[0]] = stt_pkg::mk_result(stt_pkg::K_LT,
						stt_pkg::off_field(start_q), 16'd1);
					n = n + 2'd1;
				end
				default: ;
			endcase
			r[n[0]] = stt_pkg::mk_result(stt_pkg::K_EOF, stt_pkg::off_field(rpos_q), 16'd0);
			n = n + 2'd1;
			// end of text: everything back to reset values
			mode_d  = M_IDLE;
			pend_d  = P_NONE;
			saw_d   = 1'b0;
			rpos_d  = '0;
			start_d = '0;
			run_d   = '0;
			hits_d  = '1;
		end else begin
			case (mode_q)
				M_LINE: begin
					fresh = 1'b0;
					if (byte_in == 8'h0a)
						mode_d = M_IDLE;
				end
				M_BLOCK: begin
					fresh = 1'b0;
					if (byte_in == 8'h3e) begin
						if (saw_q) begin
							mode_d = M_IDLE;
							saw_d  = 1'b0;
						end else begin
							saw_d = 1'b1;
						end
					end else begin
						saw_d = 1'b0;
					end
				end
				M_STR: begin
					fresh = 1'b0;
					if (byte_in == 8'h22) begin
						r[n[0]] = stt_pkg::mk_result(stt_pkg::K_STRING,
							stt_pkg::off_field(start_q), stt_pkg::len_field(run_q));
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						run_d = run_bump;
					end
				end
				M_NUM: begin
					if (is_dig || byte_in == 8'h2e) begin
						run_d = run_bump;
						fresh = 1'b0;
					end else begin
						r[n[0]] = stt_pkg::mk_result(stt_pkg::K_NUMBER,
							stt_pkg::off_field(start_q), stt_pkg::len_field(run_q));
						n = n + 2'd1;
						mode_d = M_IDLE;
					end
				end
				M_IDENT: begin
					if (is_idc) begin
						hits_d = hits_q & keep;
						run_d  = run_bump;
						fresh  = 1'b0;
					end else begin
						r[n[0]] = stt_pkg::mk_result(ident_kind,
							stt_pkg::off_field(start_q), stt_pkg::len_field(run_q));
						n = n + 2'd1;
						mode_d = M_IDLE;
					end
				end
				default: mode_d = M_IDLE;
			endcase

			// held operator: pair it with this byte, open a comment with it, or flush it
			if (fresh && pend_q != P_NONE) begin
				pend_d = P_NONE;
				if ((pend_q == P_PLUS && byte_in == 8'h3e)
				    || (pend_q == P_MINUS && byte_in == 8'h3c)
				    || (pend_q == P_AMP && byte_in == 8'h26)
				    || (pend_q == P_BAR && byte_in == 8'h7c)
				    || (pend_q == P_EQ && byte_in == 8'h3d)) begin
					case (pend_q)
						P_PLUS:  r[n[0]] = stt_pkg::mk_result(stt_pkg::K_PLUS_GT,
							stt_pkg::off_field(start_q), 16'd2);
						P_MINUS: r[n[0]] = stt_pkg::mk_result(stt_pkg::K_MINUS_LT,
							stt_pkg::off_field(start_q), 16'd2);
						P_AMP:   r[n[0]] = stt_pkg::mk_result(stt_pkg::K_AND_AND,
							stt_pkg::off_field(start_q), 16'd2);
						P_BAR:   r[n[0]] = stt_pkg::mk_result(stt_pkg::K_OR_OR,
							stt_pkg::off_field(start_q), 16'd2);
						default: r[n[0]] = stt_pkg::mk_result(stt_pkg::K_EQ_EQ,
							stt_pkg::off_field(start_q), 16'd2);
					endcase
					n = n + 2'd1;
					fresh = 1'b0;
				end else if (pend_q == P_LESS && byte_in == 8'h3c) begin
					mode_d = M_BLOCK;
					saw_d  = 1'b0;
					fresh  = 1'b0;
				end else if (pend_q == P_TILDE && byte_in == 8'h7e) begin
					mode_d = M_LINE;
					fresh  = 1'b0;
				end else begin
					case (pend_q)
						P_PLUS: begin
							r[n[0]] = stt_pkg::mk_result(stt_pkg::K_PLUS,
								stt_pkg::off_field(start_q), 16'd1);
							n = n + 2'd1;
						end
						P_MINUS: begin
							r[n[0]] = stt_pkg::mk_result(stt_pkg::K_MINUS,
								stt_pkg::off_field(start_q), 16'd1);
							n = n + 2'd1;
						end
						P_EQ: begin
							r[n[0]] = stt_pkg::mk_result(stt_pkg::K_EQ,
								stt_pkg::off_field(start_q), 16'd1);
							n = n + 2'd1;
						end
						P_LESS: begin
							r[n[0]] = stt_pkg::mk_result(stt_pkg::K_LT,
								stt_pkg::off_field(start_q), 16'd1);
							n = n + 2'd1;
						end
						default: ;
					endcase
				end
			end

			if (fresh) begin
				if (is_dig) begin
					mode_d  = M_NUM;
					start_d = rpos_q;
					run_d   = stt_pkg::len_t'(1);
				end else if (is_alp || byte_in == 8'h5f) begin
					mode_d  = M_IDENT;
					start_d = rpos_q;
					hits_d  = first_hit;
					run_d   = stt_pkg::len_t'(1);
				end else if (byte_in == 8'h22) begin
					mode_d  = M_STR;
					start_d = rpos_q + 1'b1;
					run_d   = '0;
				end else begin
					case (byte_in)
						8'h2b: begin pend_d = P_PLUS;  start_d = rpos_q; end
						8'h2d: begin pend_d = P_MINUS; start_d = rpos_q; end
						8'h26: begin pend_d = P_AMP;   start_d = rpos_q; end
						8'h7c: begin pend_d = P_BAR;   start_d = rpos_q; end
						8'h3d: begin pend_d = P_EQ;    start_d = rpos_q; end
						8'h3c: begin pend_d = P_LESS;  start_d = rpos_q; end
						8'h7e: begin pend_d = P_TILDE; start_d = rpos_q; end
						8'h21, 8'h3e, 8'h7b, 8'h7d, 8'h28, 8'h29, 8'h5b, 8'h5d: begin
							case (byte_in)
								8'h21:   r[n[0]].kind = stt_pkg::K_BANG;
								8'h3e:   r[n[0]].kind = stt_pkg::K_GT;
								8'h7b:   r[n[0]].kind = stt_pkg::K_LBRACE;
								8'h7d:   r[n[0]].kind = stt_pkg::K_RBRACE;
								8'h28:   r[n[0]].kind = stt_pkg::K_LPAREN;
								8'h29:   r[n[0]].kind = stt_pkg::K_RPAREN;
								8'h5b:   r[n[0]].kind = stt_pkg::K_LBRACK;
								default: r[n[0]].kind = stt_pkg::K_RBRACK;
							endcase
							r[n[0]].start  = stt_pkg::off_field(rpos_q);
							r[n[0]].length = 16'd1;
							r[n[0]].last   = 1'b0;
							n = n + 2'd1;
						end
						default: ;
					endcase
				end
			end

			rpos_d = rpos_q + 1'b1;
		end

		if (n == 2'd1)
			r[0].last = 1'b1;
		if (n == 2'd2)
			r[1].last = 1'b1;

		res_cnt = n;
		res[0]  = r[0];
		res[1]  = r[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pend_q  <= P_NONE;
			saw_q   <= 1'b0;
			rpos_q  <= '0;
			start_q <= '0;
			run_q   <= '0;
			hits_q  <= '1;
		end else if (go) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			saw_q   <= saw_d;
			rpos_q  <= rpos_d;
			start_q <= start_d;
			run_q   <= run_d;
			hits_q  <= hits_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/stt_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_outq
// Two-entry token queue; takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module stt_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       push_cnt,
	input  wire stt_pkg::result_t push_data [2],
	input  wire logic             pop,
	output logic [1:0]            count,
	output stt_pkg::result_t      head
);

	stt_pkg::result_t slot_q [2];
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             wr;

	// caller pushes only when cnt_q + push_cnt <= 2, so no live entry is overwritten
	assign wr    = rd_q ^ cnt_q[0];
	assign count = cnt_q;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			slot_q[wr] <= push_data[0];
		if (push_cnt == 2'd2)
			slot_q[~wr] <= push_data[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q - {1'b0, pop} + push_cnt;
		end
	end

endmodule
`default_nettype wire

>>> dv/tb_source_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Feeds directed and random source text into the tokenizer byte by byte,
// predicts every token in a scanner of its own and checks each token field by
// field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_BYTES = 1230;
	localparam int LONG_RUN     = 48;
	localparam int CALM_FROM    = 800;
	localparam int CALM_TO      = 1400;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_STRING, SCAN_LINE_NOTE, SCAN_BLOCK_NOTE
	} scan_e;

	typedef enum logic [2:0] {
		HOLD_NONE, HOLD_PLUS, HOLD_MINUS, HOLD_AMP, HOLD_BAR, HOLD_EQ, HOLD_LESS, HOLD_TILDE
	} hold_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        token_valid;
	logic        token_ready = 1'b0;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	source_text_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_byte    (text_byte),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scanner copy
	scan_e             scan = SCAN_IDLE;
	hold_e             held_op = HOLD_NONE;
	bit                close_seen = 1'b0;
	stt_pkg::offset_t  next_pos = '0;
	stt_pkg::offset_t  tok_start = '0;
	stt_pkg::len_t     run_len = '0;
	stt_pkg::kw_hits_t kw_live = '1;

	logic [7:0]       source_bytes[$];
	stt_pkg::result_t expected_tokens[$];

	int          cycles = 0;
	int          mismatches = 0;
	int          bytes_fed = 0;
	int          tokens_checked = 0;
	int          texts_ended = 0;
	int          saturated_tokens = 0;
	logic [35:0] kinds_seen = '0;

	wire calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

	function automatic string keyword_text(input int k);
		string s;
		case (k)
			0: begin
				s = "ri";
				s = {s, "ven"};
			end
			1:  s = "core";
			2:  s = "stamp";
			3:  s = "grab";
			4:  s = "consistof";
			5:  s = "if";
			6:  s = "altif";
			7:  s = "else";
			8:  s = "flow";
			9:  s = "during";
			10: s = "craft";
			11: s = "returns";
			12: s = "and";
			13: s = "or";
			default: s = "not";
		endcase
		return s;
	endfunction

	function automatic bit is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic void note_token(input stt_pkg::kind_t kind,
	                                   input stt_pkg::offset_t start,
	                                   input stt_pkg::len_t length);
		stt_pkg::result_t r;
		r.kind   = kind;
		r.start  = start;
		r.length = length;
		r.last   = 1'b0;
		expected_tokens.push_back(r);
	endfunction

	function automatic void grow_run();
		if (run_len != '1)
			run_len++;
	endfunction

	function automatic void match_keywords(input logic [7:0] b);
		string s;
		int    k;
		for (k = 0; k < stt_pkg::KW_COUNT; k++) begin
			s = keyword_text(k);
			if (!(run_len < s.len() && s[run_len] == b))
				kw_live[k] = 1'b0;
		end
	endfunction

	function automatic void close_scan();
		stt_pkg::kind_t kind;
		string          s;
		int             k;
		case (scan)
			SCAN_NUMBER: note_token(stt_pkg::K_NUMBER, tok_start, run_len);
			SCAN_STRING: note_token(stt_pkg::K_STRING, tok_start, run_len);
			SCAN_IDENT: begin
				// scan downward so the lowest matching keyword wins
				kind = stt_pkg::K_IDENT;
				for (k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
					s = keyword_text(k);
					if (kw_live[k] && run_len == s.len())
						kind = stt_pkg::kind_t'(stt_pkg::K_KW0 + k);
				end
				note_token(kind, tok_start, run_len);
			end
			default: ;
		endcase
		scan = SCAN_IDLE;
	endfunction

	function automatic void flush_held();
		case (held_op)
			HOLD_PLUS:  note_token(stt_pkg::K_PLUS, tok_start, 16'd1);
			HOLD_MINUS: note_token(stt_pkg::K_MINUS, tok_start, 16'd1);
			HOLD_EQ:    note_token(stt_pkg::K_EQ, tok_start, 16'd1);
			HOLD_LESS:  note_token(stt_pkg::K_LT, tok_start, 16'd1);
			default: ;
		endcase
		held_op = HOLD_NONE;
	endfunction

	function automatic void clear_scanner();
		scan       = SCAN_IDLE;
		held_op    = HOLD_NONE;
		close_seen = 1'b0;
		next_pos   = '0;
		tok_start  = '0;
		run_len    = '0;
		kw_live    = '1;
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		stt_pkg::offset_t pos;
		bit               fresh;
		int               produced;
		stt_pkg::kind_t   kind;
		produced = expected_tokens.size();
		pos      = next_pos;
		fresh    = 1'b1;
		kind     = stt_pkg::K_EOF;
		if (b == 8'h00) begin
			close_scan();
			flush_held();
			note_token(stt_pkg::K_EOF, pos, '0);
			clear_scanner();
		end else begin
			case (scan)
				SCAN_LINE_NOTE: begin
					if (b == 8'h0A)
						scan = SCAN_IDLE;
					fresh = 1'b0;
				end
				SCAN_BLOCK_NOTE: begin
					if (b == ">") begin
						if (close_seen) begin
							scan       = SCAN_IDLE;
							close_seen = 1'b0;
						end else begin
							close_seen = 1'b1;
						end
					end else begin
						close_seen = 1'b0;
					end
					fresh = 1'b0;
				end
				SCAN_STRING: begin
					if (b == "\"")
						close_scan();
					else
						grow_run();
					fresh = 1'b0;
				end
				SCAN_NUMBER: begin
					if (is_digit(b) || b == ".") begin
						grow_run();
						fresh = 1'b0;
					end else begin
						close_scan();
					end
				end
				SCAN_IDENT: begin
					if (is_alpha(b) || is_digit(b) || b == "_") begin
						match_keywords(b);
						grow_run();
						fresh = 1'b0;
					end else begin
						close_scan();
					end
				end
				default: scan = SCAN_IDLE;
			endcase

			// a held operator char pairs with this byte, opens a comment, or is flushed
			if (fresh && held_op != HOLD_NONE) begin
				if (held_op == HOLD_PLUS && b == ">")
					kind = stt_pkg::K_PLUS_GT;
				else if (held_op == HOLD_MINUS && b == "<")
					kind = stt_pkg::K_MINUS_LT;
				else if (held_op == HOLD_AMP && b == "&")
					kind = stt_pkg::K_AND_AND;
				else if (held_op == HOLD_BAR && b == "|")
					kind = stt_pkg::K_OR_OR;
				else if (held_op == HOLD_EQ && b == "=")
					kind = stt_pkg::K_EQ_EQ;
				if (kind != stt_pkg::K_EOF) begin
					note_token(kind, tok_start, 16'd2);
					held_op = HOLD_NONE;
					fresh   = 1'b0;
				end else if (held_op == HOLD_LESS && b == "<") begin
					scan       = SCAN_BLOCK_NOTE;
					close_seen = 1'b0;
					held_op    = HOLD_NONE;
					fresh      = 1'b0;
				end else if (held_op == HOLD_TILDE && b == "~") begin
					scan    = SCAN_LINE_NOTE;
					held_op = HOLD_NONE;
					fresh   = 1'b0;
				end else begin
					flush_held();
				end
			end

			if (fresh) begin
				if (is_digit(b)) begin
					scan      = SCAN_NUMBER;
					tok_start = pos;
					run_len   = 16'd1;
				end else if (is_alpha(b) || b == "_") begin
					scan      = SCAN_IDENT;
					tok_start = pos;
					run_len   = '0;
					kw_live   = '1;
					match_keywords(b);
					run_len   = 16'd1;
				end else if (b == "\"") begin
					scan      = SCAN_STRING;
					tok_start = pos + 1'b1;
					run_len   = '0;
				end else begin
					case (b)
						"+": held_op = HOLD_PLUS;
						"-": held_op = HOLD_MINUS;
						"&": held_op = HOLD_AMP;
						"|": held_op = HOLD_BAR;
						"=": held_op = HOLD_EQ;
						"<": held_op = HOLD_LESS;
						"~": held_op = HOLD_TILDE;
						"!": kind = stt_pkg::K_BANG;
						">": kind = stt_pkg::K_GT;
						"{": kind = stt_pkg::K_LBRACE;
						"}": kind = stt_pkg::K_RBRACE;
						"(": kind = stt_pkg::K_LPAREN;
						")": kind = stt_pkg::K_RPAREN;
						"[": kind = stt_pkg::K_LBRACK;
						"]": kind = stt_pkg::K_RBRACK;
						default: ;
					endcase
					if (held_op != HOLD_NONE)
						tok_start = pos;
					else if (kind != stt_pkg::K_EOF)
						note_token(kind, pos, 16'd1);
				end
			end
			next_pos = pos + 1'b1;
		end
		if (expected_tokens.size() > produced)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endfunction

	// stimulus helpers
	function automatic void put_byte(input logic [7:0] b);
		source_bytes.push_back(b);
	endfunction

	function automatic void put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			source_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(0, 3))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			2: return 8'("0" + $urandom_range(0, 9));
			default: return "_";
		endcase
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 3))
			0: return "\t";
			1: return 8'h0D;
			2: return 8'h0A;
			default: return " ";
		endcase
	endfunction

	// byte side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_byte  <= 8'h00;
		end else if (!text_valid || text_ready) begin
			if (source_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
				text_valid <= 1'b1;
				text_byte  <= source_bytes.pop_front();
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			token_ready <= 1'b0;
		else
			token_ready <= calm || ($urandom_range(0, 99) >= 16);
	end

	// token side: predict on each accepted byte, check each accepted token
	always @(posedge clk or negedge arst_n) begin : token_check
		stt_pkg::result_t got;
		stt_pkg::result_t want;
		if (!arst_n) begin
			clear_scanner();
		end else begin
			if (text_valid && text_ready) begin
				bytes_fed++;
				predict_byte(text_byte);
			end
			if (token_valid && token_ready) begin
				got.kind   = token_kind;
				got.start  = token_start;
				got.length = token_length;
				got.last   = last_of_run;
				tokens_checked++;
				if (token_kind < 6'd36)
					kinds_seen[token_kind] = 1'b1;
				if (token_kind == stt_pkg::K_EOF)
					texts_ended++;
				if (token_length == 16'hFFFF)
					saturated_tokens++;
				if (expected_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: token with none expected:", $realtime,
						         " kind %0d start %0d len %0d last %0b",
						         got.kind, got.start, got.length, got.last);
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: token %0d mismatch:", $realtime, tokens_checked,
							         " expected kind %0d start %0d len %0d last %0b,",
							         want.kind, want.start, want.length, want.last,
							         " got kind %0d start %0d len %0d last %0b",
							         got.kind, got.start, got.length, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d tokens still expected",
			         cycles, expected_tokens.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : run
		string      ops[17];
		string      s;
		int         stop_at;
		int         n;
		int         i;
		logic [7:0] c;
		ops = '{"+>", "-<", "&&", "||", "!", "==", "=", "+", "-", "<", ">",
		        "{", "}", "(", ")", "[", "]"};

		// directed: every operator but a lone minus, comments, the two-token bytes, end-of-text flushes
		put_text("x+>-<&&||!===+-<>{}()[]~~c");
		put_byte(8'h80);
		put_byte(8'h0A);
		put_text("<<a>>>1.2.3\t\"s");
		put_byte(8'hFF);
		put_text("\"if)&|~ +(");
		put_byte(8'h00);
		put_text("9");
		put_byte(8'h00);
		put_text("\"open");
		put_byte(8'h00);
		put_text("<");
		put_byte(8'h00);
		put_text("<<x>");
		put_byte(8'h00);

		// random: mostly well-formed tokens with random content, some noise
		stop_at = source_bytes.size() + RANDOM_BYTES;
		while (source_bytes.size() < stop_at) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: begin
					s = keyword_text($urandom_range(0, stt_pkg::KW_COUNT - 1));
					case ($urandom_range(0, 3))
						0: put_text(s.substr(0, s.len() - 2));
						1: begin
							put_text(s);
							put_byte(rand_word_char());
						end
						default: put_text(s);
					endcase
				end
				5, 6: begin
					put_byte($urandom_range(0, 1) ? "_" : 8'("a" + $urandom_range(0, 25)));
					repeat ($urandom_range(0, 7))
						put_byte(rand_word_char());
				end
				7, 8: begin
					put_byte(8'("0" + $urandom_range(0, 9)));
					repeat ($urandom_range(0, 5))
						put_byte($urandom_range(0, 3) == 0 ? "." : 8'("0" + $urandom_range(0, 9)));
				end
				9, 10: begin
					put_byte("\"");
					repeat ($urandom_range(0, 6)) begin
						c = 8'($urandom_range(1, 255));
						put_byte(c == "\"" ? "q" : c);
					end
					if ($urandom_range(0, 7) != 0)
						put_byte("\"");
				end
				11, 12, 13, 14: put_text(ops[$urandom_range(0, 16)]);
				15: begin
					put_text("~~");
					repeat ($urandom_range(0, 6)) begin
						c = 8'($urandom_range(1, 255));
						put_byte(c == 8'h0A ? "z" : c);
					end
					if ($urandom_range(0, 5) != 0)
						put_byte(8'h0A);
				end
				16: begin
					put_text("<<");
					repeat ($urandom_range(0, 8)) begin
						case ($urandom_range(0, 3))
							0: put_byte(">");
							1: put_byte("<");
							2: put_byte(" ");
							default: put_byte(8'($urandom_range(1, 255)));
						endcase
					end
					if ($urandom_range(0, 7) != 0)
						put_text(">>");
				end
				17: put_byte(8'($urandom_range(1, 255)));
				18: repeat ($urandom_range(1, 3)) put_byte(rand_blank());
				default: put_byte(8'h00);
			endcase
			if ($urandom_range(0, 1))
				put_byte(rand_blank());
		end
		put_byte(8'h00);

		// one long identifier that starts like a keyword, closed by a bracket
		put_text("returns");
		for (i = 7; i < LONG_RUN; i++)
			put_byte(rand_word_char());
		put_text(")");
		put_byte(8'h00);
		n = source_bytes.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (source_bytes.size() != 0 || text_valid || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d of %0d bytes over %0d texts, %0d tokens checked, %0d of 36 kinds seen.",
		         bytes_fed, n, texts_ended, tokens_checked, $countones(kinds_seen));
		$display("Saturated-length tokens: %0d, mismatches: %0d.", saturated_tokens, mismatches);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
